[rtl/dq_pkg.sv]
package dq_pkg;

  localparam int unsigned ActionWidth = 3;
  localparam int unsigned StatusWidth = 4;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned RestrWidth  = 2;

  // Restriction register bits.
  localparam int unsigned RestrNoFrontPush = 0;
  localparam int unsigned RestrNoFrontPop  = 1;

  typedef enum logic [ActionWidth-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LIST       = 3'd4,
    ACT_CLEAR      = 3'd5
  } dq_action_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_INSERTED     = 4'd0,
    ST_REMOVED      = 4'd1,
    ST_REMOVED_LAST = 4'd2,
    ST_EMPTY        = 4'd3,
    ST_FULL         = 4'd4,
    ST_REFUSED      = 4'd5,
    ST_ENTRY        = 4'd6,
    ST_LIST_EMPTY   = 4'd7,
    ST_CLEARED      = 4'd8
  } dq_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } dq_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;        // run a single-result action on the accepted item
    logic list_start;  // begin a listing: read the front entry
    logic list_step;   // emit the entry read last and read the next one
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;    // output register holds an item not yet taken
    logic empty;       // no entries stored
    logic list_last;   // the entry about to be emitted is the back entry
  } dq_stat_t;

endpackage

[rtl/dq_ctrl.sv]
module dq_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [dq_pkg::ActionWidth-1:0]       action_i,
  input  logic                                 out_ready_i,
  input  dq_pkg::dq_stat_t                     stat_i,
  output logic                                 in_ready_o,
  output dq_pkg::dq_cmd_t                      cmd_o
);
  import dq_pkg::*;

  dq_state_e state_q, state_d;
  logic      out_free;
  logic      accept;
  logic      is_list;

  assign out_free = !stat_i.out_busy || out_ready_i;
  assign is_list  = (action_i == ACT_LIST) && !stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && out_free && is_list) begin
          state_d = S_LIST;
        end
      end
      S_LIST: begin
        if (out_free && stat_i.list_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    accept            = 1'b0;
    cmd_o.exec        = 1'b0;
    cmd_o.list_start  = 1'b0;
    cmd_o.list_step   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o       = out_free;
        accept           = in_valid_i && out_free;
        cmd_o.list_start = accept && is_list;
        cmd_o.exec       = accept && !is_list;
      end
      S_LIST: begin
        cmd_o.list_step = out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/dq_datapath.sv]
module dq_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dq_pkg::dq_cmd_t                      cmd_i,
  output dq_pkg::dq_stat_t                     stat_o,
  input  logic                                 cfg_we_i,
  input  logic [dq_pkg::RestrWidth-1:0]        cfg_wdata_i,
  input  logic [dq_pkg::ActionWidth-1:0]       action_i,
  input  logic [dq_pkg::WordWidth-1:0]         value_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [dq_pkg::StatusWidth-1:0]       out_status_o,
  output logic [dq_pkg::WordWidth-1:0]         out_value_o,
  output logic                                 out_last_o
);
  import dq_pkg::*;

  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned EXT_W = (DATA_WIDTH > WordWidth) ? DATA_WIDTH : WordWidth;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    if (p == '0) begin
      return PW'(DEPTH - 1);
    end
    return p - PW'(1);
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [RestrWidth-1:0] restr_q;
  logic [PW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [PW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]         idx_q, idx_d;
  logic [DATA_WIDTH-1:0] rd_q;

  logic                  out_valid_q;
  dq_status_e            out_status_q;
  logic [WordWidth-1:0]  out_value_q;
  logic                  out_last_q;

  logic                  mem_we;
  logic [PW-1:0]         mem_waddr;
  logic                  mem_re;
  logic [PW-1:0]         mem_raddr;
  dq_status_e            exec_status;

  logic                  full, empty, only_one;
  logic [CW:0]           tail_sum;
  logic [PW-1:0]         tail_ptr;
  logic [PW-1:0]         head_dec;

  logic signed [WordWidth-1:0]  value_s;
  logic signed [EXT_W-1:0]      value_ext;
  logic [DATA_WIDTH-1:0]        wr_word;
  logic signed [DATA_WIDTH-1:0] rd_s;
  logic signed [EXT_W-1:0]      rd_ext;

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign only_one = (count_q == CW'(1));
  assign head_dec = ptr_dec(head_q);

  // The slot behind the back entry is head plus count, wrapped once since the sum stays below twice the depth.
  assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign tail_ptr = (tail_sum >= (CW + 1)'(DEPTH)) ? PW'(tail_sum - (CW + 1)'(DEPTH))
                                                   : PW'(tail_sum);

  assign value_s   = value_i;
  assign value_ext = EXT_W'(value_s);
  assign wr_word   = value_ext[DATA_WIDTH-1:0];
  assign rd_s      = rd_q;
  assign rd_ext    = EXT_W'(rd_s);

  assign stat_o.out_busy  = out_valid_q;
  assign stat_o.empty     = empty;
  assign stat_o.list_last = (CW'(idx_q) == count_q - CW'(1));

  always_comb begin
    exec_status = ST_REFUSED;
    head_d      = head_q;
    count_d     = count_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_ptr;
    unique case (action_i)
      ACT_PUSH_FRONT: begin
        if (restr_q[RestrNoFrontPush]) begin
          exec_status = ST_REFUSED;
        end else if (full) begin
          exec_status = ST_FULL;
        end else begin
          exec_status = ST_INSERTED;
          mem_we      = 1'b1;
          mem_waddr   = head_dec;
          head_d      = head_dec;
          count_d     = count_q + CW'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          exec_status = ST_FULL;
        end else begin
          exec_status = ST_INSERTED;
          mem_we      = 1'b1;
          count_d     = count_q + CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (restr_q[RestrNoFrontPop]) begin
          exec_status = ST_REFUSED;
        end else if (empty) begin
          exec_status = ST_EMPTY;
        end else begin
          exec_status = only_one ? ST_REMOVED_LAST : ST_REMOVED;
          head_d      = ptr_inc(head_q);
          count_d     = count_q - CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          exec_status = ST_EMPTY;
        end else begin
          exec_status = only_one ? ST_REMOVED_LAST : ST_REMOVED;
          count_d     = count_q - CW'(1);
        end
      end
      ACT_LIST: begin
        exec_status = ST_LIST_EMPTY;
      end
      ACT_CLEAR: begin
        exec_status = ST_CLEARED;
        head_d      = '0;
        count_d     = '0;
      end
      default: exec_status = ST_REFUSED;
    endcase
  end

  // A listing walks a read pointer from the front; the memory read runs one entry ahead.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    idx_d     = idx_q;
    if (cmd_i.list_start) begin
      mem_re    = 1'b1;
      mem_raddr = head_q;
      rd_ptr_d  = ptr_inc(head_q);
      idx_d     = '0;
    end else if (cmd_i.list_step) begin
      mem_re   = 1'b1;
      rd_ptr_d = ptr_inc(rd_ptr_q);
      idx_d    = idx_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem[mem_waddr] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restr_q     <= '0;
      head_q      <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        restr_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      rd_ptr_q <= rd_ptr_d;
      idx_q    <= idx_d;
      if (cmd_i.exec || cmd_i.list_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= exec_status;
      out_value_q  <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.list_step) begin
      out_status_q <= ST_ENTRY;
      out_value_q  <= rd_ext[WordWidth-1:0];
      out_last_q   <= stat_o.list_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;

endmodule

[rtl/double_ended_queue_core.sv]
// Double-ended queue of signed words in a ring memory of DEPTH entries, kept as a
// head pointer and an entry count. Each input item carries an action in tuser and
// a push word in tdata; every action answers with a status in tuser, and a list
// action answers with one item per stored entry, front to back, tlast on the back
// one. Push, pop, clear and the other single-answer actions can follow back to back
// while results are taken. The ring memory has one registered read port, so during a
// list the front entry is read when the listing starts, before the first answer, and
// each following entry is read while the previous one is sent.
// No item is taken during a listing. Results sit in an output register, so a new
// item is taken in the cycle its predecessor's result is taken. The restriction
// register refuses front pushes (bit 0) and front pops (bit 1); write it while idle.
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dq_pkg::RestrWidth-1:0]        cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [dq_pkg::WordWidth-1:0]         s_axis_tdata,  // [31:0] value
  input  logic [dq_pkg::ActionWidth-1:0]       s_axis_tuser,  // [2:0] action
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [dq_pkg::WordWidth-1:0]         m_axis_tdata,  // [31:0] entry_value
  output logic [dq_pkg::StatusWidth-1:0]       m_axis_tuser,  // [3:0] status
  output logic                                 m_axis_tlast
);
  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .action_i    (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (s_axis_tuser),
    .value_i      (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_value_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  // At most one command at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("controller issued more than one command");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec || cmd.list_step) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten before it was taken");

  // Once a listing starts, no item is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.list_start |=> !s_axis_tready)
    else $error("item taken during a listing");

  // Only listed entries can be followed by more results of the same item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == ST_ENTRY))
    else $error("non-final result that is not a listed entry");

endmodule
